FILE: rtl/first_fit_heap_allocator_assert.svh
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_assert.svh
// assertion macros of the heap allocator checker
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg
// shared types, constants and helpers of the first-fit heap allocator
// ---------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_UNITS = 4096;
	localparam int UNIT_W     = $clog2(HEAP_UNITS);
	localparam int UNIT_SHIFT = 2;
	localparam int HDR_UNITS  = 6;
	localparam int MIN_UNITS  = 3;
	localparam int LO_UNITS   = 16;
	localparam int CAP_UNITS  = HEAP_UNITS - 2 * HDR_UNITS;
	localparam int CMD_W      = 3;
	localparam int REQ_W      = 16;
	localparam int ADDR_W     = 14;
	localparam int BYTES_W    = 15;
	localparam int NSU_W      = 15;
	localparam int STAT_W     = 2;

	typedef logic [UNIT_W-1:0] ptr_t;
	typedef logic [UNIT_W:0]   ext_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 3'd0,
		CMD_ALLOC   = 3'd1,
		CMD_FREE    = 3'd2,
		CMD_REALLOC = 3'd3,
		CMD_SIZE    = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_NOMEM = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [REQ_W-1:0]  request_bytes;
		logic [ADDR_W-1:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  result_addr;
		logic [STAT_W-1:0]  status;
		logic [BYTES_W-1:0] block_bytes;
		logic [BYTES_W-1:0] copy_bytes;
		logic [BYTES_W-1:0] used_bytes;
		logic [BYTES_W-1:0] peak_bytes;
	} res_t;

	typedef struct packed {
		ptr_t raddr;
		logic nx_we;
		ptr_t nx_wa;
		ptr_t nx_wd;
		logic pv_we;
		ptr_t pv_wa;
		ptr_t pv_wd;
		logic us_we;
		ptr_t us_wa;
		logic us_wd;
	} mem_ctl_t;

	typedef struct packed {
		ptr_t nxt;
		ptr_t prv;
		logic used;
	} node_t;

	// usable units of the block with header h and next header n
	function automatic ptr_t blk_units(ptr_t h, ptr_t n);
		ext_t lim;
		lim = {1'b0, h} + ext_t'(HDR_UNITS);
		return ({1'b0, n} >= lim) ? ptr_t'(n - h - ptr_t'(HDR_UNITS)) : '0;
	endfunction

endpackage

FILE: rtl/ffha_ram.sv
// ---------------------------------------------------------------------------
// ffha_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

FILE: rtl/ffha_core.sv
// ---------------------------------------------------------------------------
// ffha_core
// command sequencer: header walk, split, merge and counter updates
// ---------------------------------------------------------------------------
module ffha_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ffha_pkg::ADDR_W-1:0]  heap_bytes,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  ffha_pkg::req_t               req,
	output logic                         res_valid,
	input  logic                         res_ready,
	output ffha_pkg::res_t               res,
	output ffha_pkg::mem_ctl_t           mem,
	input  ffha_pkg::node_t              rd
);
	import ffha_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE  = 19'b0000000000000000001,
		S_DISP  = 19'b0000000000000000010,
		S_INIT0 = 19'b0000000000000000100,
		S_INIT1 = 19'b0000000000000001000,
		S_FRD   = 19'b0000000000000010000,
		S_FCHK  = 19'b0000000000000100000,
		S_TLOOP = 19'b0000000000001000000,
		S_TCHK  = 19'b0000000000010000000,
		S_TSPL  = 19'b0000000000100000000,
		S_TMARK = 19'b0000000001000000000,
		S_LRD   = 19'b0000000010000000000,
		S_LCHK  = 19'b0000000100000000000,
		S_RRD   = 19'b0000001000000000000,
		S_R1    = 19'b0000010000000000000,
		S_R2    = 19'b0000100000000000000,
		S_R3    = 19'b0001000000000000000,
		S_SHR0  = 19'b0010000000000000000,
		S_SHR1  = 19'b0100000000000000000,
		S_DONE  = 19'b1000000000000000000
	} state_t;

	state_t              state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [NSU_W-1:0]    nsu_q;
	logic [ADDR_W-1:0]   addr_q;
	ptr_t                p_q, h_q, hn_q, hp_q, n_q, t2_q, sz_q, su_q;
	ptr_t                lf_q, span_q, end_q;
	logic                split_q, ready_q;
	logic [BYTES_W-1:0]  used_q, peak_q;
	logic [ADDR_W-1:0]   raddr_q;
	logic [STAT_W-1:0]   stat_q;
	logic [BYTES_W-1:0]  bb_q, cb_q;

	logic [REQ_W:0]      nsum;
	logic [NSU_W-1:0]    nsu_w, su_take, re_lim;
	logic                take_ok, find_bad, move;
	ptr_t                hu, init_su, fsz, gap, p2_take, p2_shr, add_units, rel_sz, min_sz;
	logic                fits_hdr, fit, do_split, merge_n, merge_p;
	logic [BYTES_W-1:0]  used_add, used_rel, used_shr, dec_b, rel_b;

	assign nsum     = {1'b0, req.request_bytes} + (REQ_W+1)'(3);
	assign nsu_w    = nsum[REQ_W:UNIT_SHIFT];
	assign su_take  = (nsu_q < NSU_W'(MIN_UNITS)) ? NSU_W'(MIN_UNITS) : nsu_q;
	assign take_ok  = ready_q && (su_take <= NSU_W'(span_q));
	assign re_lim   = ready_q ? NSU_W'(span_q) : '0;
	assign find_bad = !ready_q || (addr_q == '0) || (addr_q[UNIT_SHIFT-1:0] != '0)
		|| (addr_q[ADDR_W-1:UNIT_SHIFT] < ptr_t'(HDR_UNITS));
	assign move     = (cmd_q == CMD_REALLOC) && (addr_q != '0);

	assign hu       = heap_bytes[ADDR_W-1:UNIT_SHIFT];
	assign init_su  = (hu < ptr_t'(LO_UNITS)) ? ptr_t'(LO_UNITS)
		: ((hu > ptr_t'(CAP_UNITS)) ? ptr_t'(CAP_UNITS) : hu);

	assign fsz      = blk_units(h_q, rd.nxt);
	assign fits_hdr = {1'b0, rd.nxt} >= ({1'b0, p_q} + ext_t'(HDR_UNITS));
	assign gap      = ptr_t'(rd.nxt - p_q - ptr_t'(HDR_UNITS));
	assign fit      = !rd.used && fits_hdr && (gap >= su_q);
	assign do_split = {1'b0, gap} >= ({1'b0, su_q} + ext_t'(HDR_UNITS + MIN_UNITS));
	assign p2_take  = p_q + ptr_t'(HDR_UNITS) + su_q;
	assign p2_shr   = h_q + ptr_t'(HDR_UNITS) + nsu_q[UNIT_W-1:0];
	assign add_units = do_split ? ptr_t'(su_q + ptr_t'(HDR_UNITS)) : ptr_t'(rd.nxt - p_q);
	assign used_add = used_q + BYTES_W'({add_units, 2'b00});
	assign min_sz   = (NSU_W'(sz_q) < nsu_q) ? sz_q : nsu_q[UNIT_W-1:0];

	assign rel_sz   = blk_units(h_q, rd.nxt) + ptr_t'(HDR_UNITS);
	assign rel_b    = BYTES_W'({rel_sz, 2'b00});
	assign used_rel = (used_q >= rel_b) ? used_q - rel_b : '0;
	assign dec_b    = BYTES_W'({ptr_t'(sz_q - nsu_q[UNIT_W-1:0]), 2'b00});
	assign used_shr = (used_q >= dec_b) ? used_q - dec_b : '0;

	assign merge_n  = (h_q != hn_q) && !rd.used && (hn_q != end_q);
	assign merge_p  = (hp_q != h_q) && !rd.used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
			lf_q    <= '0;
			used_q  <= '0;
			peak_q  <= '0;
			span_q  <= '0;
			end_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req.cmd;
						nsu_q   <= nsu_w;
						addr_q  <= req.block_addr;
						raddr_q <= '0;
						stat_q  <= ST_OK;
						bb_q    <= '0;
						cb_q    <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (cmd_q)
						CMD_INIT: begin
							span_q  <= init_su;
							end_q   <= init_su + ptr_t'(HDR_UNITS);
							lf_q    <= '0;
							used_q  <= '0;
							peak_q  <= '0;
							ready_q <= 1'b1;
							bb_q    <= BYTES_W'({init_su, 2'b00});
							state_q <= S_INIT0;
						end
						CMD_ALLOC: begin
							if (nsu_q != '0 && take_ok) begin
								su_q    <= su_take[UNIT_W-1:0];
								p_q     <= lf_q;
								state_q <= S_TLOOP;
							end else begin
								stat_q  <= ST_NOMEM;
								state_q <= S_DONE;
							end
						end
						CMD_FREE, CMD_SIZE: begin
							if (cmd_q == CMD_FREE && addr_q == '0) begin
								state_q <= S_DONE;
							end else if (find_bad) begin
								stat_q  <= ST_BAD;
								state_q <= S_DONE;
							end else begin
								h_q     <= ptr_t'(addr_q[ADDR_W-1:UNIT_SHIFT] - ptr_t'(HDR_UNITS));
								p_q     <= '0;
								state_q <= S_FRD;
							end
						end
						CMD_REALLOC: begin
							if (nsu_q > re_lim || (nsu_q == '0 && addr_q == '0)) begin
								stat_q  <= ST_NOMEM;
								state_q <= S_DONE;
							end else if (addr_q == '0) begin
								if (take_ok) begin
									su_q    <= su_take[UNIT_W-1:0];
									p_q     <= lf_q;
									state_q <= S_TLOOP;
								end else begin
									stat_q  <= ST_NOMEM;
									state_q <= S_DONE;
								end
							end else if (find_bad) begin
								stat_q  <= ST_BAD;
								state_q <= S_DONE;
							end else begin
								h_q     <= ptr_t'(addr_q[ADDR_W-1:UNIT_SHIFT] - ptr_t'(HDR_UNITS));
								p_q     <= '0;
								state_q <= S_FRD;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_INIT0: begin
					state_q <= S_INIT1;
				end
				S_INIT1: begin
					state_q <= S_DONE;
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (p_q == h_q) begin
						if (!rd.used) begin
							stat_q  <= ST_BAD;
							state_q <= S_DONE;
						end else begin
							hn_q <= rd.nxt;
							sz_q <= fsz;
							if (cmd_q == CMD_SIZE) begin
								raddr_q <= addr_q;
								bb_q    <= BYTES_W'({fsz, 2'b00});
								state_q <= S_DONE;
							end else if (cmd_q == CMD_FREE || nsu_q == '0) begin
								state_q <= S_RRD;
							end else if (NSU_W'(fsz) == nsu_q) begin
								raddr_q <= addr_q;
								bb_q    <= BYTES_W'({fsz, 2'b00});
								state_q <= S_DONE;
							end else if (nsu_q + NSU_W'(HDR_UNITS + MIN_UNITS) < NSU_W'(fsz)) begin
								state_q <= S_SHR0;
							end else begin
								su_q    <= su_take[UNIT_W-1:0];
								p_q     <= lf_q;
								state_q <= S_TLOOP;
							end
						end
					end else if (rd.nxt <= p_q || rd.nxt == end_q) begin
						stat_q  <= ST_BAD;
						state_q <= S_DONE;
					end else begin
						p_q     <= rd.nxt;
						state_q <= S_FRD;
					end
				end
				S_TLOOP: begin
					if (p_q > ptr_t'(span_q - su_q)) begin
						stat_q  <= ST_NOMEM;
						state_q <= S_DONE;
					end else begin
						state_q <= S_TCHK;
					end
				end
				S_TCHK: begin
					if (fit) begin
						n_q     <= rd.nxt;
						split_q <= do_split;
						t2_q    <= p2_take;
						used_q  <= used_add;
						if (peak_q < used_add) begin
							peak_q <= used_add;
						end
						raddr_q <= ADDR_W'({ptr_t'(p_q + ptr_t'(HDR_UNITS)), 2'b00});
						bb_q    <= BYTES_W'({(do_split ? su_q : gap), 2'b00});
						if (move) begin
							cb_q <= BYTES_W'({min_sz, 2'b00});
						end
						state_q <= do_split ? S_TSPL : S_TMARK;
					end else if (rd.nxt <= p_q) begin
						stat_q  <= ST_NOMEM;
						state_q <= S_DONE;
					end else begin
						p_q     <= rd.nxt;
						state_q <= S_TLOOP;
					end
				end
				S_TSPL: begin
					state_q <= S_TMARK;
				end
				S_TMARK: begin
					if (p_q == lf_q) begin
						state_q <= S_LRD;
					end else begin
						state_q <= move ? S_RRD : S_DONE;
					end
				end
				S_LRD: begin
					state_q <= S_LCHK;
				end
				S_LCHK: begin
					if (rd.used && lf_q != end_q) begin
						lf_q    <= rd.nxt;
						state_q <= S_LRD;
					end else begin
						state_q <= move ? S_RRD : S_DONE;
					end
				end
				S_RRD: begin
					state_q <= S_R1;
				end
				S_R1: begin
					hn_q   <= rd.nxt;
					hp_q   <= rd.prv;
					used_q <= used_rel;
					if (h_q < lf_q) begin
						lf_q <= h_q;
					end
					state_q <= S_R2;
				end
				S_R2: begin
					if (merge_n) begin
						if (lf_q == hn_q) begin
							lf_q <= h_q;
						end
						hn_q <= rd.nxt;
					end
					state_q <= S_R3;
				end
				S_R3: begin
					if (merge_p && lf_q == h_q) begin
						lf_q <= hp_q;
					end
					state_q <= S_DONE;
				end
				S_SHR0: begin
					t2_q    <= p2_shr;
					used_q  <= used_shr;
					if (p2_shr < lf_q) begin
						lf_q <= p2_shr;
					end
					raddr_q <= addr_q;
					bb_q    <= BYTES_W'({nsu_q[UNIT_W-1:0], 2'b00});
					state_q <= S_SHR1;
				end
				S_SHR1: begin
					hp_q    <= h_q;
					h_q     <= t2_q;
					state_q <= S_R2;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		mem       = '0;
		mem.raddr = p_q;
		unique case (state_q)
			S_INIT0: begin
				mem.nx_we = 1'b1; mem.nx_wa = '0; mem.nx_wd = end_q;
				mem.pv_we = 1'b1; mem.pv_wa = '0; mem.pv_wd = '0;
				mem.us_we = 1'b1; mem.us_wa = '0; mem.us_wd = 1'b0;
			end
			S_INIT1: begin
				mem.nx_we = 1'b1; mem.nx_wa = end_q; mem.nx_wd = end_q;
				mem.pv_we = 1'b1; mem.pv_wa = end_q; mem.pv_wd = end_q;
				mem.us_we = 1'b1; mem.us_wa = end_q; mem.us_wd = 1'b1;
			end
			S_TSPL: begin
				mem.nx_we = 1'b1; mem.nx_wa = t2_q; mem.nx_wd = n_q;
				mem.pv_we = 1'b1; mem.pv_wa = t2_q; mem.pv_wd = p_q;
				mem.us_we = 1'b1; mem.us_wa = t2_q; mem.us_wd = 1'b0;
			end
			S_TMARK: begin
				mem.us_we = 1'b1; mem.us_wa = p_q; mem.us_wd = 1'b1;
				mem.nx_we = split_q; mem.nx_wa = p_q; mem.nx_wd = t2_q;
				mem.pv_we = split_q && (n_q != end_q); mem.pv_wa = n_q; mem.pv_wd = t2_q;
			end
			S_LRD: begin
				mem.raddr = lf_q;
			end
			S_RRD: begin
				mem.raddr = h_q;
			end
			S_R1: begin
				mem.us_we = 1'b1; mem.us_wa = h_q; mem.us_wd = 1'b0;
				mem.raddr = rd.nxt;
			end
			S_R2: begin
				mem.nx_we = merge_n; mem.nx_wa = h_q; mem.nx_wd = rd.nxt;
				mem.pv_we = merge_n; mem.pv_wa = rd.nxt; mem.pv_wd = h_q;
				mem.raddr = hp_q;
			end
			S_R3: begin
				mem.nx_we = merge_p; mem.nx_wa = hp_q; mem.nx_wd = hn_q;
				mem.pv_we = merge_p; mem.pv_wa = hn_q; mem.pv_wd = hp_q;
			end
			S_SHR0: begin
				mem.nx_we = 1'b1; mem.nx_wa = p2_shr; mem.nx_wd = hn_q;
				mem.pv_we = 1'b1; mem.pv_wa = p2_shr; mem.pv_wd = h_q;
				mem.us_we = 1'b1; mem.us_wa = p2_shr; mem.us_wd = 1'b0;
			end
			S_SHR1: begin
				mem.nx_we = 1'b1; mem.nx_wa = h_q; mem.nx_wd = t2_q;
				mem.pv_we = (hn_q != end_q); mem.pv_wa = hn_q; mem.pv_wd = t2_q;
				mem.raddr = hn_q;
			end
			default: begin
				mem.raddr = p_q;
			end
		endcase
	end

	assign req_ready       = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign res.result_addr = raddr_q;
	assign res.status      = stat_q;
	assign res.block_bytes = bb_q;
	assign res.copy_bytes  = cb_q;
	assign res.used_bytes  = used_q;
	assign res.peak_bytes  = peak_q;

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap allocator with coalescing, headers kept in on-chip ram
// ---------------------------------------------------------------------------
// One request at a time; the header rams have a single registered read port,
// so each header visit is a read state and a check state. Init writes the
// first and the end header. Allocate walks the headers from the lowest free
// block and moves the lowest-free pointer past used blocks when it took
// that block. Free, size query and reallocate first walk the chain from the
// heap start to check the address; free then releases the block and merges
// it with free neighbours. Results wait in an output register so a new
// request can be taken while a result is pending.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ffha_pkg::ADDR_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ffha_pkg::CMD_W-1:0]    cmd,
	input  logic [ffha_pkg::REQ_W-1:0]    request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0]   block_addr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffha_pkg::ADDR_W-1:0]   result_addr,
	output logic [ffha_pkg::STAT_W-1:0]   status,
	output logic [ffha_pkg::BYTES_W-1:0]  block_bytes,
	output logic [ffha_pkg::BYTES_W-1:0]  copy_bytes,
	output logic [ffha_pkg::BYTES_W-1:0]  used_bytes,
	output logic [ffha_pkg::BYTES_W-1:0]  peak_bytes
);
	import ffha_pkg::*;

	logic [ADDR_W-1:0] heap_q;
	req_t              req;
	res_t              res, res_q;
	logic              res_valid, res_ready, ov_q;
	mem_ctl_t          mem;
	node_t             rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= ADDR_W'(16336);
		end else if (cfg_we) begin
			heap_q <= cfg_wdata;
		end
	end

	assign req.cmd           = cmd;
	assign req.request_bytes = request_bytes;
	assign req.block_addr    = block_addr;

	ffha_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.heap_bytes(heap_q),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem       (mem),
		.rd        (rd)
	);

	ffha_ram #(.WIDTH(UNIT_W), .DEPTH(HEAP_UNITS)) u_next_ram (
		.clk  (clk),
		.we   (mem.nx_we),
		.waddr(mem.nx_wa),
		.wdata(mem.nx_wd),
		.raddr(mem.raddr),
		.rdata(rd.nxt)
	);

	ffha_ram #(.WIDTH(UNIT_W), .DEPTH(HEAP_UNITS)) u_prev_ram (
		.clk  (clk),
		.we   (mem.pv_we),
		.waddr(mem.pv_wa),
		.wdata(mem.pv_wd),
		.raddr(mem.raddr),
		.rdata(rd.prv)
	);

	ffha_ram #(.WIDTH(1), .DEPTH(HEAP_UNITS)) u_used_ram (
		.clk  (clk),
		.we   (mem.us_we),
		.waddr(mem.us_wa),
		.wdata(mem.us_wd),
		.raddr(mem.raddr),
		.rdata(rd.used)
	);

	// output register
	assign res_ready = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid   = ov_q;
	assign result_addr = res_q.result_addr;
	assign status      = res_q.status;
	assign block_bytes = res_q.block_bytes;
	assign copy_bytes  = res_q.copy_bytes;
	assign used_bytes  = res_q.used_bytes;
	assign peak_bytes  = res_q.peak_bytes;

endmodule

FILE: rtl/ffha_checker.sv
// ---------------------------------------------------------------------------
// ffha_checker
// port-level checks of the heap allocator, bound to the top level
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [ffha_pkg::ADDR_W-1:0]   cfg_wdata,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [ffha_pkg::CMD_W-1:0]    cmd,
	input logic [ffha_pkg::REQ_W-1:0]    request_bytes,
	input logic [ffha_pkg::ADDR_W-1:0]   block_addr,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ffha_pkg::ADDR_W-1:0]   result_addr,
	input logic [ffha_pkg::STAT_W-1:0]   status,
	input logic [ffha_pkg::BYTES_W-1:0]  block_bytes,
	input logic [ffha_pkg::BYTES_W-1:0]  copy_bytes,
	input logic [ffha_pkg::BYTES_W-1:0]  used_bytes,
	input logic [ffha_pkg::BYTES_W-1:0]  peak_bytes
);
	import ffha_pkg::*;

	`FFHA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_addr) && $stable(status) && $stable(used_bytes), "result changed while stalled")
	`FFHA_ASSERT_IMP(a_peak_ge_used, out_valid, peak_bytes >= used_bytes, "peak below used")
	`FFHA_ASSERT_IMP(a_fail_empty, out_valid && status != ST_OK, result_addr == '0 && copy_bytes == '0, "failed request reports an address")
	`FFHA_ASSERT_IMP(a_copy_moved, out_valid && copy_bytes != '0, status == ST_OK && result_addr != '0, "copy length without a moved block")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
